/* sv/lqs_pkg.sv */
package lqs_pkg;

  localparam int FUNC_W = 2;
  localparam int WORD_W = 32;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_ENQ    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

/* sv/linear_queue_with_search_top.sv */
// Linear (non-circular) queue of DEPTH signed 32-bit words with a search
// command. func selects enqueue, dequeue or search; every command returns one
// result carrying status, the dequeued word, the match position and the
// empty/full flags after the command. Slots are not reused until the queue
// drains completely. One command is handled at a time: a command moves from
// S_IDLE to S_EXEC, then to S_DONE for enqueue, an unused code or an
// underflow, through S_FETCH for a dequeue, or through S_SCAN for a search,
// which compares up to DEPTH words from head toward tail and stops at the
// first match or at the tail. The search cost comes from reading the slot
// memory through its single registered read port, one word per cycle.
// out_valid is high in S_DONE until the result transfers; a new command is
// taken the cycle after the result transfers.
module linear_queue_with_search_top
  import lqs_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [FUNC_W-1:0]        func,
  input  logic signed [WORD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STAT_W-1:0]        status,
  output logic signed [WORD_W-1:0] read_word,
  output logic [POS_W-1:0]         position,
  output logic                     is_empty,
  output logic                     is_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  state_t state, state_next;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;

  logic [FUNC_W-1:0] op;
  logic [WORD_W-1:0] key;
  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;
  logic              empty_flag;
  logic [AW-1:0]     idx;

  logic          full;
  logic [AW-1:0] tail_new;
  logic          in_xfer;
  logic          out_xfer;
  logic          hit;
  logic          enq_write;

  assign full      = !empty_flag && (tail == LAST);
  assign tail_new  = empty_flag ? '0 : AW'(tail + 1'b1);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;
  assign hit       = (rd_data == key);
  assign enq_write = (state == S_EXEC) && (op == FUNC_ENQ) && !full;

  assign is_empty = empty_flag;
  assign is_full  = full;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (op == FUNC_DEQ && !empty_flag) begin
          state_next = S_FETCH;
        end else if (op == FUNC_SEARCH && !empty_flag) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FETCH: state_next = S_DONE;
      S_SCAN: begin
        if (hit || idx == tail) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_xfer) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // handshake and memory read address
  always_comb begin
    in_stall  = (state != S_IDLE);
    out_valid = (state == S_DONE);
    rd_addr   = (state == S_SCAN) ? AW'(idx + 1'b1) : head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (enq_write) begin
      mem[tail_new] <= key;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      empty_flag <= 1'b1;
    end else begin
      case (state)
        S_EXEC: begin
          if (enq_write) begin
            if (empty_flag) head <= '0;
            tail       <= tail_new;
            empty_flag <= 1'b0;
          end
        end
        S_FETCH: begin
          if (head == tail) begin
            head       <= '0;
            tail       <= '0;
            empty_flag <= 1'b1;
          end else begin
            head <= AW'(head + 1'b1);
          end
        end
        default: ;
      endcase
    end
  end

  // command latch, scan index and result register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op  <= func;
      key <= value;
    end
    case (state)
      S_EXEC: begin
        idx       <= head;
        status    <= ST_OK;
        read_word <= '0;
        position  <= '0;
        case (op) inside
          FUNC_ENQ: begin
            if (full) status <= ST_OVERFLOW;
          end
          FUNC_DEQ, FUNC_SEARCH: begin
            if (empty_flag) status <= ST_UNDERFLOW;
          end
          default: ;
        endcase
      end
      S_FETCH: read_word <= rd_data;
      S_SCAN: begin
        if (hit) begin
          position <= POS_W'(idx);
        end else if (idx == tail) begin
          status <= ST_NOT_FOUND;
        end else begin
          idx <= AW'(idx + 1'b1);
        end
      end
      default: ;
    endcase
  end

  // a command is only taken with no result pending
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input ready while a result is pending");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    is_full |-> !is_empty)
    else $error("queue flagged full and empty at once");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_UNDERFLOW |-> is_empty)
    else $error("underflow reported on a non-empty queue");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !empty_flag && idx >= head && idx <= tail)
    else $error("search index outside head..tail");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("result presented twice");

endmodule

/* tb/linear_queue_with_search_top_tb.sv */
module linear_queue_with_search_top_tb;
  import lqs_pkg::*;

  localparam int DEPTH        = 16;
  localparam int RANDOM_OPS   = 800;
  localparam int HOLD_START   = 150;
  localparam int HOLD_LEN     = 80;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;

  // code the block takes but does nothing with
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] read_word;
    logic [POS_W-1:0]         position;
    logic                     is_empty;
    logic                     is_full;
  } result_t;

  typedef struct {
    logic [FUNC_W-1:0]        op;
    logic signed [WORD_W-1:0] word;
    bit                       pinned;
    result_t                  want;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [FUNC_W-1:0]        func = FUNC_ENQ;
  logic signed [WORD_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] read_word;
  logic [POS_W-1:0]         position;
  logic                     is_empty;
  logic                     is_full;

  // queue image kept by the testbench
  logic signed [WORD_W-1:0] model_slot [DEPTH];
  logic [POS_W-1:0]         model_head = '0;
  logic [POS_W-1:0]         model_tail = '0;
  logic                     model_empty = 1'b1;

  result_t   pending_results[$];
  stim_row_t stim_rows[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;
  result_t   seen;
  result_t   want;

  linear_queue_with_search_top #(.DEPTH(DEPTH)) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .read_word(read_word),
    .position (position),
    .is_empty (is_empty),
    .is_full  (is_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic model_full();
    return !model_empty && model_tail == POS_W'(DEPTH - 1);
  endfunction

  // advance the queue image by one command and return what the block must report
  function automatic result_t apply_command(logic [FUNC_W-1:0] op,
                                            logic signed [WORD_W-1:0] word);
    result_t r;
    bit      hit;
    r   = '0;
    hit = 1'b0;
    case (op)
      FUNC_ENQ: begin
        if (model_full()) begin
          r.status = ST_OVERFLOW;
        end else begin
          if (model_empty) begin
            model_head  = '0;
            model_tail  = '0;
            model_empty = 1'b0;
          end else begin
            model_tail = model_tail + 1'b1;
          end
          model_slot[model_tail] = word;
        end
      end
      FUNC_DEQ: begin
        if (model_empty) begin
          r.status = ST_UNDERFLOW;
        end else begin
          r.read_word = model_slot[model_head];
          if (model_head == model_tail) begin
            model_head  = '0;
            model_tail  = '0;
            model_empty = 1'b1;
          end else begin
            model_head = model_head + 1'b1;
          end
        end
      end
      FUNC_SEARCH: begin
        if (model_empty) begin
          r.status = ST_UNDERFLOW;
        end else begin
          for (int i = model_head; i <= model_tail; i++) begin
            if (!hit && model_slot[i] == word) begin
              hit        = 1'b1;
              r.position = POS_W'(i);
            end
          end
          if (!hit) r.status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    r.is_empty = model_empty;
    r.is_full  = model_full();
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return -32'sd1;
      3: return '0;
      // narrow pool so duplicates show up and first-match gets exercised
      4, 5: return $signed(32'($urandom_range(7))) - 32'sd4;
      default: return $signed($urandom());
    endcase
  endfunction

  task automatic add_row(logic [FUNC_W-1:0] op, logic signed [WORD_W-1:0] word);
    stim_row_t row;
    row.op     = op;
    row.word   = word;
    row.pinned = 1'b0;
    row.want   = '0;
    stim_rows.push_back(row);
  endtask

  task automatic add_checked(logic [FUNC_W-1:0] op, logic signed [WORD_W-1:0] word,
                             logic [STAT_W-1:0] st, logic signed [WORD_W-1:0] rd,
                             logic [POS_W-1:0] pos, logic e, logic f);
    stim_row_t row;
    row.op     = op;
    row.word   = word;
    row.pinned = 1'b1;
    row.want   = {st, rd, pos, e, f};
    stim_rows.push_back(row);
  endtask

  // offer one command, hold it until the transfer, then predict its result
  task automatic send(logic [FUNC_W-1:0] op, logic signed [WORD_W-1:0] word,
                      output result_t predicted);
    if (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    value    <= word;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = apply_command(op, word);
  endtask

  task automatic report_mismatch(string what, result_t exp_r, result_t got_r);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected st=%0d word=%0d pos=%0d empty=%0b full=%0b,",
               $time, what, exp_r.status, exp_r.read_word, exp_r.position, exp_r.is_empty,
               exp_r.is_full,
               " got st=%0d word=%0d pos=%0d empty=%0b full=%0b",
               got_r.status, got_r.read_word, got_r.position, got_r.is_empty,
               got_r.is_full);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      seen = {status, read_word, position, is_empty, is_full};
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, seen);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) report_mismatch("result mismatch", want, seen);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: one long hold-off early on, quiet while the sender runs calm
  initial begin : receiver
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
        out_stall <= 1'b1;
      else if (calm)
        out_stall <= 1'b0;
      else
        out_stall <= ($urandom_range(99) < 29);
    end
  end

  initial begin : stimulus
    result_t                  r;
    logic [FUNC_W-1:0]        op;
    logic signed [WORD_W-1:0] word;
    int                       ops;
    int                       n;
    int                       roll;
    bit                       fill_mode;

    foreach (model_slot[i]) model_slot[i] = '0;

    add_checked(FUNC_DEQ,    '0,      ST_UNDERFLOW, '0, '0, 1'b1, 1'b0);
    add_checked(FUNC_SEARCH, '0,      ST_UNDERFLOW, '0, '0, 1'b1, 1'b0);
    add_checked(FUNC_UNUSED, -32'sd1, ST_OK,        '0, '0, 1'b1, 1'b0);
    add_checked(FUNC_ENQ,    32'sd5,  ST_OK,        '0, '0, 1'b0, 1'b0);
    // last word out: pointers go back to slot 0
    add_checked(FUNC_DEQ,    '0,      ST_OK,    32'sd5, '0, 1'b1, 1'b0);
    add_checked(FUNC_ENQ,    WORD_MIN, ST_OK,       '0, '0, 1'b0, 1'b0);
    add_row(FUNC_ENQ, WORD_MAX);
    add_row(FUNC_ENQ, -32'sd1);
    add_row(FUNC_ENQ, '0);
    add_row(FUNC_ENQ, 32'sd1);
    add_row(FUNC_ENQ, 32'sh55555555);
    add_row(FUNC_ENQ, 32'shaaaaaaaa);
    add_row(FUNC_ENQ, 32'sd7);
    add_row(FUNC_ENQ, 32'sd7);
    add_row(FUNC_ENQ, -32'sd7);
    add_row(FUNC_ENQ, 32'sh12345678);
    add_row(FUNC_ENQ, 32'sh0f0f0f0f);
    add_row(FUNC_ENQ, 32'shf0f0f0f0);
    add_row(FUNC_ENQ, 32'sd2);
    add_row(FUNC_ENQ, 32'sd3);
    add_checked(FUNC_ENQ,    32'sd7,  ST_OK,        '0, '0, 1'b0, 1'b1);
    add_checked(FUNC_ENQ,    32'sd9,  ST_OVERFLOW,  '0, '0, 1'b0, 1'b1);
    add_row(FUNC_SEARCH, 32'sd7);
    add_checked(FUNC_SEARCH, 32'sh13579bdf, ST_NOT_FOUND, '0, '0, 1'b0, 1'b1);
    add_checked(FUNC_DEQ,    '0,      ST_OK,  WORD_MIN, '0, 1'b0, 1'b1);
    // no wraparound: tail still in the last slot after a dequeue
    add_checked(FUNC_ENQ,    32'sd9,  ST_OVERFLOW,  '0, '0, 1'b0, 1'b1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[k]) begin
      send(stim_rows[k].op, stim_rows[k].word, r);
      pending_results.push_back(stim_rows[k].pinned ? stim_rows[k].want : r);
    end

    ops       = 0;
    n         = 0;
    fill_mode = 1'b0;
    while (ops < RANDOM_OPS) begin
      calm = (n >= 200 && n < 330);
      if (n == 450) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end

      if (model_empty) fill_mode = 1'b1;
      else if (model_full()) fill_mode = 1'b0;
      else if ($urandom_range(19) == 0) fill_mode = !fill_mode;

      roll = $urandom_range(99);
      if (roll < 3) op = FUNC_UNUSED;
      else if (roll < (fill_mode ? 68 : 18)) op = FUNC_ENQ;
      else if (roll < (fill_mode ? 83 : 78)) op = FUNC_DEQ;
      else op = FUNC_SEARCH;

      if (op == FUNC_SEARCH && !model_empty && $urandom_range(99) < 60)
        word = model_slot[$urandom_range(model_tail, model_head)];
      else
        word = pick_word();

      send(op, word, r);
      pending_results.push_back(r);
      if (op != FUNC_UNUSED) ops++;
      n++;
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/lqs_pkg.sv
sv/linear_queue_with_search_top.sv
tb/linear_queue_with_search_top_tb.sv
